>>> rtl/assert_macros.svh
// Assertion macros shared by the RTL of the cosine table interpolator.
// Clock is clk, reset is rst in every module that includes this file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property outside reset.
`define CTBI_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check a property on every edge, reset included.
`define CTBI_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> rtl/ctbi_pkg.sv
// Shared constants, types and the cosine table builder for the interpolator.
// No dependencies; the ROM module and the top level import it.
package ctbi_pkg;

  localparam int TABLE_LOG2    = 10;
  localparam int OUT_FRAC_BITS = 16;

  localparam int PHASE_W  = 32;
  localparam int TAB_SIZE = 1 << TABLE_LOG2;
  localparam int FRAC_W   = PHASE_W - TABLE_LOG2;
  localparam int ENTRY_W  = OUT_FRAC_BITS + 2;
  localparam int DIFF_W   = ENTRY_W + 1;
  localparam int PROD_W   = DIFF_W + FRAC_W + 1;
  localparam int ROUND_SH = 62 - OUT_FRAC_BITS;

  localparam logic [63:0] HALF_PI_Q62 = 64'h6487ED5110B4611A;
  localparam logic [63:0] TAB_QTR     = 64'(TAB_SIZE / 4);
  // quarter turn split into a whole step per table index and a remainder
  localparam logic [63:0] HALF_PI_STEP = HALF_PI_Q62 / TAB_QTR;
  localparam logic [63:0] HALF_PI_REM  = HALF_PI_Q62 % TAB_QTR;
  localparam logic signed [ENTRY_W-1:0] ONE_Q = ENTRY_W'(1 << OUT_FRAC_BITS);

  typedef logic signed [ENTRY_W-1:0] entry_t;
  typedef entry_t rom_t [0:TAB_SIZE];

  typedef struct packed {
    logic                  en;
    logic [TABLE_LOG2-1:0] idx;
  } rom_req_t;

  typedef struct packed {
    entry_t left;
    entry_t right;
  } rom_pair_t;

  // (a * b) >> 62, truncated to 64 bits, for Q2.62 operands
  function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[125:62];
  endfunction

  // Restoring unsigned division; only runs while the table is built
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q;
    logic [64:0] rem;
    q   = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem  = rem - {1'b0, den};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // cos(2*pi*r/TAB_SIZE) for r in the first quadrant, Taylor series in Q2.62
  function automatic entry_t quarter_cos(input logic [63:0] r);
    logic [63:0]        ang;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic [63:0]        dv;
    logic [63:0]        s;
    logic signed [63:0] sum;
    ang  = HALF_PI_STEP * r + ((HALF_PI_REM * r) >> (TABLE_LOG2 - 2));
    x2   = mul_q62(ang, ang);
    term = 64'd1 << 62;
    sum  = $signed(term);
    for (int n = 1; n <= 24; n++) begin
      if (term != 64'd0) begin
        dv   = 64'((2 * n - 1) * (2 * n));
        term = udiv64(mul_q62(term, x2), dv);
        if ((n & 1) != 0) begin
          sum = sum - $signed(term);
        end else begin
          sum = sum + $signed(term);
        end
      end
    end
    if (sum < 0) begin
      sum = 64'sd0;
    end
    s = $unsigned(sum);
    s = (s + (64'd1 << (ROUND_SH - 1))) >> ROUND_SH;
    return entry_t'(s[ENTRY_W-1:0]);
  endfunction

  // Fold the full-turn index onto the first quadrant and restore the sign
  function automatic entry_t table_entry(input int m);
    int q;
    q = TAB_SIZE / 4;
    if (m <= q) begin
      return quarter_cos(64'(m));
    end else if (m <= 2 * q) begin
      return -quarter_cos(64'(2 * q - m));
    end else if (m <= 3 * q) begin
      return -quarter_cos(64'(m - 2 * q));
    end
    return quarter_cos(64'(4 * q - m));
  endfunction

  function automatic rom_t cos_table_build();
    rom_t t;
    for (int i = 0; i <= TAB_SIZE; i++) begin
      t[i] = table_entry(i);
    end
    return t;
  endfunction

endpackage

>>> rtl/ctbi_rom.sv
// Cosine ROM with two registered read ports: entries idx and idx + 1.
// Contents are built at elaboration by ctbi_pkg::cos_table_build.
module ctbi_rom (
  input  logic                clk,
  input  ctbi_pkg::rom_req_t  req,
  output ctbi_pkg::rom_pair_t rd
);
  import ctbi_pkg::*;

  localparam rom_t COS_ROM = cos_table_build();

  logic [TABLE_LOG2:0] addr_lo;
  logic [TABLE_LOG2:0] addr_hi;

  assign addr_lo = {1'b0, req.idx};
  assign addr_hi = addr_lo + 1'b1;

  // hold the read data while the pipeline stalls
  always_ff @(posedge clk) begin
    if (req.en) begin
      rd.left  <= COS_ROM[addr_lo];
      rd.right <= COS_ROM[addr_hi];
    end
  end

endmodule

>>> rtl/cosine_table_interpolator_core.sv
// Cosine table interpolator: 32-bit phase (one turn = 2^32) to signed Q1.16.
// One word per cycle while out_ready is high; a stall holds both stages.
// Stage 1 is the registered dual-port ROM read, stage 2 the interpolation
// multiply and add into the output register.
// Reset (rst, synchronous) empties both stages; the ROM needs no fill.
module cosine_table_interpolator_core
  import ctbi_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [PHASE_W-1:0]        phase_turns,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [ENTRY_W-1:0] cosine_value
);
  `include "assert_macros.svh"

  logic              adv1;
  logic              adv2;
  logic              s1_valid;
  logic [FRAC_W-1:0] frac1;
  rom_req_t          rom_req;
  rom_pair_t         rom_rd;

  logic signed [DIFF_W-1:0]  diff;
  logic signed [PROD_W-1:0]  prod;
  logic signed [PROD_W-1:0]  prod_sh;
  logic signed [DIFF_W-1:0]  sum;
  logic signed [ENTRY_W-1:0] cosine_next;

  assign adv2     = !out_valid || out_ready;
  assign adv1     = !s1_valid || adv2;
  assign in_ready = adv1;

  assign rom_req.en  = adv1;
  assign rom_req.idx = phase_turns[PHASE_W-1:FRAC_W];

  ctbi_rom u_rom (
    .clk (clk),
    .req (rom_req),
    .rd  (rom_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv1) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      frac1 <= phase_turns[FRAC_W-1:0];
    end
  end

  // arithmetic shift of the signed product floors toward minus infinity
  assign diff        = DIFF_W'(rom_rd.right) - DIFF_W'(rom_rd.left);
  assign prod        = PROD_W'(diff) * $signed({1'b0, frac1});
  assign prod_sh     = prod >>> FRAC_W;
  assign sum         = DIFF_W'(rom_rd.left) + prod_sh[DIFF_W-1:0];
  assign cosine_next = sum[ENTRY_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv2) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv2 && s1_valid) begin
      cosine_value <= cosine_next;
    end
  end

  `CTBI_ASSERT_ALWAYS(a_rst_empty, rst |=> (!s1_valid && !out_valid), "reset left a word in flight")
  `CTBI_ASSERT(a_accept_load, (in_valid && in_ready) |=> s1_valid, "accepted word lost at stage 1")
  `CTBI_ASSERT(a_s1_hold, (s1_valid && !adv2) |=> (s1_valid && $stable(frac1)), "stage 1 moved under stall")
  `CTBI_ASSERT(a_out_load, (s1_valid && adv2) |=> out_valid, "stage 1 word not moved to output")
  `CTBI_ASSERT(a_range, out_valid |-> (cosine_value <= ONE_Q && cosine_value >= -ONE_Q), "cosine out of range")

endmodule

>>> bench/tb_cosine_table_interpolator_core.sv
// Self-checking bench for cosine_table_interpolator_core: phase words in, Q1.16 cosine out.
// Builds its own cosine table and interpolation predictor; needs only ctbi_pkg and the core.
module tb_cosine_table_interpolator_core;
  timeunit 1ns;
  timeprecision 1ps;

  import ctbi_pkg::*;

  localparam int RAND_WORDS   = 1200;
  localparam int HOLD_CYCLES  = 80;
  localparam int HOLD_WORDS   = 48;
  localparam int DRAIN_CYCLES = 16;
  localparam int MAX_SHOWN    = 10;
  localparam int RND_SH       = 62 - OUT_FRAC_BITS;

  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic               known;
    entry_t             val;
  } dir_row_t;

  localparam int NDIR = 22;

  // Quadrant points carry their cosine; the rest go through the predictor.
  dir_row_t dir_rows [NDIR] = '{
    '{32'h0000_0000, 1'b1, ONE_Q},
    '{32'h4000_0000, 1'b1, '0},
    '{32'h8000_0000, 1'b1, -ONE_Q},
    '{32'hC000_0000, 1'b1, '0},
    '{32'hFFC0_0000, 1'b0, '0},
    '{32'hFFFF_FFFF, 1'b0, '0},
    '{32'hFFFF_FFFE, 1'b0, '0},
    '{32'h0000_0001, 1'b0, '0},
    '{32'h003F_FFFF, 1'b0, '0},
    '{32'h0040_0000, 1'b0, '0},
    '{32'h0020_0000, 1'b0, '0},
    '{32'h2000_0000, 1'b0, '0},
    '{32'h3FFF_FFFF, 1'b0, '0},
    '{32'h4000_0001, 1'b0, '0},
    '{32'h7FFF_FFFF, 1'b0, '0},
    '{32'h8000_0001, 1'b0, '0},
    '{32'hBFFF_FFFF, 1'b0, '0},
    '{32'hC000_0001, 1'b0, '0},
    '{32'h5555_5555, 1'b0, '0},
    '{32'hAAAA_AAAA, 1'b0, '0},
    '{32'h1234_5678, 1'b0, '0},
    '{32'hEDCB_A987, 1'b0, '0}
  };

  logic               clk;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [PHASE_W-1:0] phase_turns = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  entry_t             cosine_value;

  // Travel with the payload: a typed-in expectation overrides the predictor.
  logic               word_known = 1'b0;
  entry_t             word_exp = '0;

  longint cos_lut [0:TAB_SIZE];
  entry_t cos_due_q [$];
  int     words_sent;
  int     words_checked;
  int     bad_words;
  int     holds_asked;

  cosine_table_interpolator_core dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .phase_turns  (phase_turns),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .cosine_value (cosine_value)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic [63:0] q62_mul(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] wide;
    wide = {64'd0, a} * {64'd0, b};
    return wide[125:62];
  endfunction

  // First-quadrant cosine of step r, Taylor sum in unsigned Q2.62, rounded half up.
  function automatic longint quadrant_cos(input longint unsigned r);
    longint unsigned qtr;
    longint unsigned ang;
    longint unsigned sq;
    longint unsigned term;
    longint          acc;
    qtr  = TAB_SIZE / 4;
    ang  = (HALF_PI_Q62 / qtr) * r + ((HALF_PI_Q62 % qtr) * r) / qtr;
    sq   = q62_mul(ang, ang);
    term = 64'd1 << 62;
    acc  = longint'(term);
    for (int k = 1; k <= 24; k++) begin
      if (term != 0) begin
        term = q62_mul(term, sq) / longint'(unsigned'((2 * k - 1) * (2 * k)));
        if (k % 2 == 1) begin
          acc = acc - longint'(term);
        end else begin
          acc = acc + longint'(term);
        end
      end
    end
    if (acc < 0) begin
      acc = 0;
    end
    return longint'((longint'(unsigned'(acc)) + (64'd1 << (RND_SH - 1))) >> RND_SH);
  endfunction

  // Floor interpolation between the two neighboring table entries.
  function automatic entry_t interp_cosine(input logic [PHASE_W-1:0] ph);
    int unsigned slot;
    longint      frac;
    longint      lo;
    longint      delta;
    slot  = ph[PHASE_W-1:FRAC_W];
    frac  = longint'({1'b0, ph[FRAC_W-1:0]});
    lo    = cos_lut[slot];
    delta = cos_lut[slot + 1] - lo;
    return entry_t'(lo + ((delta * frac) >>> FRAC_W));
  endfunction

  function automatic logic [PHASE_W-1:0] pick_phase();
    logic [PHASE_W-1:0]    ph;
    logic [TABLE_LOG2-1:0] slot;
    int unsigned           kind;
    kind = $urandom_range(0, 9);
    ph   = $urandom;
    case (kind)
      6: ph[FRAC_W-1:0] = '0;
      7: ph[FRAC_W-1:0] = '1;
      8: begin
        // land on or just below a quadrant boundary, wrap included
        slot = TABLE_LOG2'($urandom_range(0, 4) * (TAB_SIZE / 4) - $urandom_range(0, 1));
        ph[PHASE_W-1:FRAC_W] = slot;
      end
      9: ph[PHASE_W-1:16] = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
      default: ;
    endcase
    return ph;
  endfunction

  task automatic send_word(input logic [PHASE_W-1:0] ph, input logic known, input entry_t val);
    in_valid    <= 1'b1;
    phase_turns <= ph;
    word_known  <= known;
    word_exp    <= val;
    do @(posedge clk); while (!in_ready);
    words_sent++;
  endtask

  task automatic idle_for(input int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (cos_due_q.size() != 0);
  endtask

  // Scoreboard: queue a cosine per accepted phase, compare each output word in order.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        cos_due_q.push_back(word_known ? word_exp : interp_cosine(phase_turns));
      end
      if (out_valid && out_ready) begin
        if (cos_due_q.size() == 0) begin
          bad_words++;
          if (bad_words <= MAX_SHOWN) begin
            $display("%0t: unexpected output word %0d", $realtime, cosine_value);
          end
        end else begin
          if (cosine_value !== cos_due_q[0]) begin
            bad_words++;
            if (bad_words <= MAX_SHOWN) begin
              $display("%0t: cosine mismatch, expected %0d got %0d", $realtime,
                       cos_due_q[0], cosine_value);
            end
          end
          void'(cos_due_q.pop_front());
          words_checked++;
        end
      end
    end
  end

  // Receiver: random stall modes, plus long hold-offs when the sender asks for one.
  initial begin
    int holds_done;
    int mode;
    int mode_left;
    int tick;
    holds_done = 0;
    mode       = 0;
    mode_left  = 0;
    tick       = 0;
    forever begin
      if (holds_done < holds_asked) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        holds_done++;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 4);
          mode_left = $urandom_range(5, 80);
        end
        mode_left--;
        tick++;
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= ($urandom_range(0, 1) != 0);
          2: out_ready <= ($urandom_range(0, 9) != 0);
          3: out_ready <= (tick % 4 != 0);
          default: out_ready <= ($urandom_range(0, 4) == 0);
        endcase
        @(posedge clk);
      end
    end
  end

  // Stimulus
  initial begin
    int  qt;
    int  sent_rand;
    int  burst;
    bit  mid_hold;
    qt          = TAB_SIZE / 4;
    sent_rand   = 0;
    mid_hold    = 1'b0;
    words_sent    = 0;
    words_checked = 0;
    bad_words     = 0;
    holds_asked   = 0;
    for (int i = 0; i <= TAB_SIZE; i++) begin
      if (i <= qt) begin
        cos_lut[i] = quadrant_cos(i);
      end else if (i <= 2 * qt) begin
        cos_lut[i] = -quadrant_cos(2 * qt - i);
      end else if (i <= 3 * qt) begin
        cos_lut[i] = -quadrant_cos(i - 2 * qt);
      end else begin
        cos_lut[i] = quadrant_cos(4 * qt - i);
      end
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int d = 0; d < NDIR; d++) begin
      send_word(dir_rows[d].phase, dir_rows[d].known, dir_rows[d].val);
      if ($urandom_range(0, 2) == 0) begin
        idle_for($urandom_range(1, 3));
      end
    end

    // Fill the pipe against a stalled receiver, then let it drain completely.
    holds_asked++;
    for (int h = 0; h < HOLD_WORDS; h++) begin
      send_word(pick_phase(), 1'b0, '0);
    end
    wait_drained();

    while (sent_rand < RAND_WORDS) begin
      burst = $urandom_range(1, 48);
      for (int b = 0; b < burst && sent_rand < RAND_WORDS; b++) begin
        send_word(pick_phase(), 1'b0, '0);
        sent_rand++;
      end
      if (!mid_hold && sent_rand >= RAND_WORDS / 2) begin
        mid_hold = 1'b1;
        holds_asked++;
      end else if ($urandom_range(0, 3) != 0) begin
        idle_for($urandom_range(1, 16));
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d phase words (%0d directed), checked %0d cosine words, %0d long stalls.",
             words_sent, NDIR, words_checked, holds_asked);
    if (bad_words == 0 && cos_due_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d bad words, %0d still expected", bad_words, cos_due_q.size());
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d cosine words outstanding", cos_due_q.size());
    $display("TB_ERROR");
    $finish;
  end

endmodule
